FILE: sv/vm_register_alu_memory_unit_defines.svh
// assertion macros shared by the vm register alu memory unit
`ifndef VM_REGISTER_ALU_MEMORY_UNIT_DEFINES_SVH
`define VM_REGISTER_ALU_MEMORY_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define VMRU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define VMRU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define VMRU_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define VMRU_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: sv/vmru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vmru_pkg;

   localparam int unsigned NUM_REGS = 16;
   localparam int unsigned RIDX_W   = 4;
   localparam int unsigned DATA_W   = 8;
   localparam int unsigned PC_W     = 12;
   localparam int unsigned INDEX_W  = 12;

   localparam logic [PC_W-1:0]   PC_RESET = 12'd512;
   localparam logic [PC_W-1:0]   PC_SKIP  = 12'd2;
   localparam logic [RIDX_W-1:0] FLAG_REG = 4'hF;

   localparam logic [DATA_W-1:0] DEC_HUNDRED = 8'd100;
   localparam logic [DATA_W-1:0] DEC_TEN     = 8'd10;

   // operation codes
   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_SUB  = 3'd1;
   localparam logic [2:0] OP_SKIP = 3'd2;
   localparam logic [2:0] OP_BCD  = 3'd3;
   localparam logic [2:0] OP_SAVE = 3'd4;
   localparam logic [2:0] OP_LOAD = 3'd5;

   typedef struct packed {
      logic [2:0]         op;
      logic [RIDX_W-1:0]  reg_x;
      logic [RIDX_W-1:0]  reg_y;
      logic               use_flag;
      logic               swap;
      logic               invert;
      logic [DATA_W-1:0]  value_a;
      logic [DATA_W-1:0]  value_b;
      logic [INDEX_W-1:0] index_address;
   } req_type;

   typedef struct packed {
      logic [PC_W-1:0]   program_counter;
      logic [DATA_W-1:0] flag_value;
      logic [DATA_W-1:0] target_value;
   } rsp_type;

   // shared add / subtract unit
   typedef struct packed {
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic              sub;
   } alu_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] result;
      logic              carry;   // carry out on add, no borrow on subtract
   } alu_rsp_type;

   // register file port
   typedef struct packed {
      logic              we;
      logic [RIDX_W-1:0] waddr;
      logic [DATA_W-1:0] wdata;
      logic [RIDX_W-1:0] raddr_a;
      logic [RIDX_W-1:0] raddr_b;
   } rf_req_type;

endpackage

`default_nettype wire

FILE: sv/vmru_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module vmru_alu
   import vmru_pkg::*;
(
   input  alu_req_type alu_req,
   output alu_rsp_type alu_rsp
);

   logic [DATA_W-1:0] b_op;
   logic [DATA_W:0]   sum;

   assign b_op = alu_req.sub ? ~alu_req.b : alu_req.b;
   assign sum  = {1'b0, alu_req.a} + {1'b0, b_op} + {{DATA_W{1'b0}}, alu_req.sub};

   assign alu_rsp.result = sum[DATA_W-1:0];
   assign alu_rsp.carry  = sum[DATA_W];

endmodule

`default_nettype wire

FILE: sv/vmru_regfile.sv
`timescale 1ns / 1ps
`default_nettype none

module vmru_regfile
   import vmru_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  rf_req_type        rf_req,
   output logic [DATA_W-1:0] rdata_a,
   output logic [DATA_W-1:0] rdata_b
);

   logic [DATA_W-1:0]   regs_ff [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff;
   logic [DATA_W-1:0]   rdata_a_ff;
   logic [DATA_W-1:0]   rdata_b_ff;

   // entry never written since reset reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (rf_req.we) begin
         valid_ff[rf_req.waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_req.we) begin
         regs_ff[rf_req.waddr] <= rf_req.wdata;
      end
      rdata_a_ff <= valid_ff[rf_req.raddr_a] ? regs_ff[rf_req.raddr_a] : '0;
      rdata_b_ff <= valid_ff[rf_req.raddr_b] ? regs_ff[rf_req.raddr_b] : '0;
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

`default_nettype wire

FILE: sv/vmru_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module vmru_mem
   import vmru_pkg::*;
#(
   parameter int unsigned MEM_BYTES = 4096,
   localparam int unsigned ADDR_W = $clog2(MEM_BYTES)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [MEM_BYTES];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: sv/vm_register_alu_memory_unit.sv
// sequence: each request runs through its op states, then a register read and the report;
//   add / subtract read, execute and optionally write the flag; decimal digits and save /
//   load first reduce an out-of-range index_address by MEM_BYTES, one subtract per wrap
// throughput: one request at a time; start is taken again in the cycle the result shows
// reset: registers and memory read as zero, program counter 512; busy stays high while
//   the byte memory is swept clear; the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none
`include "vm_register_alu_memory_unit_defines.svh"

module vm_register_alu_memory_unit
   import vmru_pkg::*;
#(
   parameter int unsigned MEM_BYTES = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int unsigned ADDR_W = $clog2(MEM_BYTES);
   localparam int unsigned PTR_W  = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
   localparam logic [PTR_W-1:0] LAST_ADDR = PTR_W'(MEM_BYTES - 1);
   localparam logic [PTR_W-1:0] MEM_SPAN  = PTR_W'(MEM_BYTES);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_ARITH_RD,
      ST_ARITH_EX,
      ST_FLAG_WR,
      ST_SKIP,
      ST_BCD_HUND,
      ST_BCD_TEN,
      ST_BCD_ONE,
      ST_SAVE,
      ST_LOAD,
      ST_REPORT_RD,
      ST_REPORT
   } state_type;

   state_type         state_ff;
   req_type           req_ff;
   logic [PC_W-1:0]   pc_ff;
   logic [PTR_W-1:0]  ptr_ff;       // clear sweep address, then wrapped memory address
   logic [RIDX_W:0]   cnt_ff;       // next register index to move
   logic              pend_ff;      // a move was issued last cycle
   logic [RIDX_W-1:0] lag_idx_ff;   // register index issued last cycle
   logic [DATA_W-1:0] acc_ff;       // decimal remainder
   logic [3:0]        digit_ff;
   logic              flag_bit_ff;
   logic              rsp_strobe_ff;
   rsp_type           rsp_data_ff;

   alu_req_type       alu_req;
   alu_rsp_type       alu_rsp;
   rf_req_type        rf_req;
   logic [DATA_W-1:0] rf_rdata_a;
   logic [DATA_W-1:0] rf_rdata_b;
   logic              mem_we;
   logic [DATA_W-1:0] mem_wdata;
   logic [DATA_W-1:0] mem_rdata;

   logic [PTR_W-1:0]  ptr_step;
   logic              move_issue;
   logic              sub_swap;

   vmru_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   vmru_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rf_req  (rf_req),
      .rdata_a (rf_rdata_a),
      .rdata_b (rf_rdata_b)
   );

   vmru_mem #(
      .MEM_BYTES (MEM_BYTES)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .addr  (ptr_ff[ADDR_W-1:0]),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // wrapping memory address increment
   assign ptr_step   = (ptr_ff == LAST_ADDR) ? '0 : ptr_ff + PTR_W'(1);
   // registers 0..reg_x still to move
   assign move_issue = (cnt_ff <= {1'b0, req_ff.reg_x});
   assign sub_swap   = req_ff.swap && (req_ff.op == OP_SUB);

   // datapath steering for the shared alu, register file and memory
   always_comb begin
      alu_req.a   = acc_ff;
      alu_req.b   = DEC_HUNDRED;
      alu_req.sub = 1'b1;

      rf_req.we      = 1'b0;
      rf_req.waddr   = req_ff.reg_x;
      rf_req.wdata   = alu_rsp.result;
      rf_req.raddr_a = req_ff.reg_x;
      rf_req.raddr_b = req_ff.reg_y;

      mem_we    = 1'b0;
      mem_wdata = {4'b0, digit_ff};

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
         end
         ST_ARITH_EX: begin
            // reg_x on port a, reg_y on port b
            alu_req.a   = sub_swap ? rf_rdata_b : rf_rdata_a;
            alu_req.b   = sub_swap ? rf_rdata_a : rf_rdata_b;
            alu_req.sub = (req_ff.op == OP_SUB);
            rf_req.we   = 1'b1;
         end
         ST_FLAG_WR: begin
            rf_req.we    = 1'b1;
            rf_req.waddr = FLAG_REG;
            rf_req.wdata = {{(DATA_W-1){1'b0}}, flag_bit_ff};
         end
         ST_SKIP: begin
            alu_req.a = req_ff.value_a;
            alu_req.b = req_ff.value_b;
         end
         ST_BCD_HUND: begin
            mem_we = !alu_rsp.carry;
         end
         ST_BCD_TEN: begin
            alu_req.b = DEC_TEN;
            mem_we    = !alu_rsp.carry;
         end
         ST_BCD_ONE: begin
            mem_we    = 1'b1;
            mem_wdata = acc_ff;
         end
         ST_SAVE: begin
            rf_req.raddr_a = cnt_ff[RIDX_W-1:0];
            mem_we         = pend_ff;
            mem_wdata      = rf_rdata_a;
         end
         ST_LOAD: begin
            rf_req.we    = pend_ff;
            rf_req.waddr = lag_idx_ff;
            rf_req.wdata = mem_rdata;
         end
         ST_REPORT_RD: begin
            rf_req.raddr_a = FLAG_REG;
            rf_req.raddr_b = req_ff.reg_x;
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         pc_ff         <= PC_RESET;
         ptr_ff        <= '0;
         cnt_ff        <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               ptr_ff <= ptr_step;
               if (ptr_ff == LAST_ADDR) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  req_ff   <= req_data;
                  ptr_ff   <= PTR_W'(req_data.index_address);
                  cnt_ff   <= '0;
                  pend_ff  <= 1'b0;
                  acc_ff   <= req_data.value_a;
                  digit_ff <= '0;
                  priority case (req_data.op)
                     OP_ADD, OP_SUB:           state_ff <= ST_ARITH_RD;
                     OP_SKIP:                  state_ff <= ST_SKIP;
                     OP_BCD, OP_SAVE, OP_LOAD: state_ff <= ST_REDUCE;
                     default:                  state_ff <= ST_REPORT_RD;
                  endcase
               end
            end
            ST_REDUCE: begin
               // bring the base address into range, one subtract a cycle
               if (ptr_ff > LAST_ADDR) begin
                  ptr_ff <= ptr_ff - MEM_SPAN;
               end else begin
                  priority case (req_ff.op)
                     OP_BCD:  state_ff <= ST_BCD_HUND;
                     OP_SAVE: state_ff <= ST_SAVE;
                     default: state_ff <= ST_LOAD;
                  endcase
               end
            end
            ST_ARITH_RD: begin
               state_ff <= ST_ARITH_EX;
            end
            ST_ARITH_EX: begin
               flag_bit_ff <= alu_rsp.carry;
               state_ff    <= req_ff.use_flag ? ST_FLAG_WR : ST_REPORT_RD;
            end
            ST_FLAG_WR: begin
               state_ff <= ST_REPORT_RD;
            end
            ST_SKIP: begin
               if ((alu_rsp.result == '0) != req_ff.invert) begin
                  pc_ff <= pc_ff + PC_SKIP;
               end
               state_ff <= ST_REPORT_RD;
            end
            ST_BCD_HUND: begin
               if (alu_rsp.carry) begin
                  acc_ff   <= alu_rsp.result;
                  digit_ff <= digit_ff + 4'd1;
               end else begin
                  ptr_ff   <= ptr_step;
                  digit_ff <= '0;
                  state_ff <= ST_BCD_TEN;
               end
            end
            ST_BCD_TEN: begin
               if (alu_rsp.carry) begin
                  acc_ff   <= alu_rsp.result;
                  digit_ff <= digit_ff + 4'd1;
               end else begin
                  ptr_ff   <= ptr_step;
                  state_ff <= ST_BCD_ONE;
               end
            end
            ST_BCD_ONE: begin
               state_ff <= ST_REPORT_RD;
            end
            ST_SAVE: begin
               // register read issued in the cycle before the memory write
               pend_ff <= move_issue;
               if (move_issue) begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
               if (pend_ff) begin
                  ptr_ff <= ptr_step;
               end
               if (!move_issue && !pend_ff) begin
                  state_ff <= ST_REPORT_RD;
               end
            end
            ST_LOAD: begin
               // memory read issued in the cycle before the register write
               pend_ff <= move_issue;
               if (move_issue) begin
                  cnt_ff     <= cnt_ff + 5'd1;
                  lag_idx_ff <= cnt_ff[RIDX_W-1:0];
                  ptr_ff     <= ptr_step;
               end
               if (!move_issue && !pend_ff) begin
                  state_ff <= ST_REPORT_RD;
               end
            end
            ST_REPORT_RD: begin
               state_ff <= ST_REPORT;
            end
            ST_REPORT: begin
               rsp_data_ff.program_counter <= pc_ff;
               rsp_data_ff.flag_value      <= rf_rdata_a;
               rsp_data_ff.target_value    <= rf_rdata_b;
               rsp_strobe_ff               <= 1'b1;
               state_ff                    <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // a result only shows once the sequencer is back at rest
   `VMRU_ASSERT_SAME(a_strobe_idle, clock, reset, rsp_strobe, !busy, "result while busy")
   // one result per request, never two in a row
   `VMRU_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe, "double result")
   // an accepted request always starts work
   `VMRU_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "request dropped")
   // no storage writes while idle
   `VMRU_ASSERT_SAME(a_idle_quiet, clock, reset, state_ff == ST_IDLE, !rf_req.we && !mem_we,
                     "write while idle")
   // program counter moves only on a skip
   `VMRU_ASSERT_NEXT(a_pc_hold, clock, reset, state_ff != ST_SKIP, $stable(pc_ff),
                     "program counter moved outside skip")

endmodule

`default_nettype wire

FILE: tb/vm_register_alu_memory_unit_checker.sv
`timescale 1ns / 1ps

module vm_register_alu_memory_unit_checker
   import vmru_pkg::*;
#(
   parameter int unsigned MEM_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req_data,
   input  logic        rsp_strobe,
   input  rsp_type     rsp_data,
   output int unsigned mismatch_count,
   output int unsigned pending_count,
   output int unsigned checked_count
);

   // machine state as the block should hold it
   logic [DATA_W-1:0] vm_regs [NUM_REGS];
   logic [DATA_W-1:0] vm_mem  [MEM_BYTES];
   logic [PC_W-1:0]   vm_pc;

   rsp_type     machine_state_q [$];
   int unsigned field_errors;
   int unsigned results_seen;

   function automatic int unsigned mem_index(logic [INDEX_W-1:0] base, int unsigned offset);
      return (int'(base) + offset) % MEM_BYTES;
   endfunction

   // apply one request to the machine state, return what the block should report
   function automatic rsp_type execute_op(req_type r);
      logic [DATA_W:0]   sum;
      logic [DATA_W-1:0] minuend;
      logic [DATA_W-1:0] subtrahend;
      rsp_type           state_out;
      case (r.op)
         OP_ADD: begin
            sum = {1'b0, vm_regs[r.reg_x]} + {1'b0, vm_regs[r.reg_y]};
            vm_regs[r.reg_x] = sum[DATA_W-1:0];
            if (r.use_flag) vm_regs[FLAG_REG] = DATA_W'(sum[DATA_W]);
         end
         OP_SUB: begin
            minuend    = r.swap ? vm_regs[r.reg_y] : vm_regs[r.reg_x];
            subtrahend = r.swap ? vm_regs[r.reg_x] : vm_regs[r.reg_y];
            vm_regs[r.reg_x] = minuend - subtrahend;
            // flag write lands last so it wins when reg_x is the flag register
            if (r.use_flag) vm_regs[FLAG_REG] = DATA_W'(minuend >= subtrahend);
         end
         OP_SKIP: begin
            if ((r.value_a == r.value_b) != r.invert) vm_pc = vm_pc + PC_SKIP;
         end
         OP_BCD: begin
            vm_mem[mem_index(r.index_address, 0)] = (r.value_a / DEC_HUNDRED) % DEC_TEN;
            vm_mem[mem_index(r.index_address, 1)] = (r.value_a / DEC_TEN) % DEC_TEN;
            vm_mem[mem_index(r.index_address, 2)] = r.value_a % DEC_TEN;
         end
         OP_SAVE: begin
            for (int i = 0; i <= r.reg_x; i++) vm_mem[mem_index(r.index_address, i)] = vm_regs[i];
         end
         OP_LOAD: begin
            for (int i = 0; i <= r.reg_x; i++) vm_regs[i] = vm_mem[mem_index(r.index_address, i)];
         end
         default: ;
      endcase
      state_out.program_counter = vm_pc;
      state_out.flag_value      = vm_regs[FLAG_REG];
      state_out.target_value    = vm_regs[r.reg_x];
      return state_out;
   endfunction

   task automatic note_error(string what, int unsigned want, int unsigned got);
      if (field_errors < 10)
         $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
      field_errors++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (vm_regs[i]) vm_regs[i] = '0;
         foreach (vm_mem[i]) vm_mem[i] = '0;
         vm_pc = PC_RESET;
         machine_state_q.delete();
         field_errors = 0;
         results_seen = 0;
      end else begin
         // a result retires the older request before a new one is taken in the same edge
         if (rsp_strobe) begin
            if (machine_state_q.size() == 0) begin
               note_error("result with no request outstanding", 0, rsp_data);
            end else begin
               want = machine_state_q.pop_front();
               results_seen++;
               if (rsp_data.program_counter !== want.program_counter)
                  note_error("program_counter", want.program_counter, rsp_data.program_counter);
               if (rsp_data.flag_value !== want.flag_value)
                  note_error("flag_value", want.flag_value, rsp_data.flag_value);
               if (rsp_data.target_value !== want.target_value)
                  note_error("target_value", want.target_value, rsp_data.target_value);
            end
         end
         if (start && !busy) machine_state_q.push_back(execute_op(req_data));
      end
      mismatch_count <= field_errors;
      pending_count  <= machine_state_q.size();
      checked_count  <= results_seen;
   end

endmodule

FILE: tb/vm_register_alu_memory_unit_tb.sv
`timescale 1ns / 1ps

module vm_register_alu_memory_unit_tb;
   import vmru_pkg::*;

   localparam int unsigned MEM_BYTES    = 4096;
   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam int unsigned RANDOM_ITEMS = 780;
   // taken skips that walk the program counter well up from its reset value
   localparam int unsigned SWEEP_ITEMS  = 1000;

   // op codes the block leaves unused
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned checked_count;

   int unsigned idle_pct;
   int unsigned cycle_count = 0;
   int unsigned directed_sent = 0;
   int unsigned sweep_sent = 0;
   int unsigned random_sent = 0;

   always #6 clock = ~clock;

   vm_register_alu_memory_unit #(
      .MEM_BYTES (MEM_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // scoreboard sits beside the block and only watches its ports
   vm_register_alu_memory_unit_checker #(
      .MEM_BYTES (MEM_BYTES)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   // watchdog, sized for the memory sweep after reset plus every request at its slowest
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic req_type make_req(logic [2:0] op, logic [3:0] x, logic [3:0] y,
                                        logic flag, logic swp, logic inv,
                                        logic [7:0] va, logic [7:0] vb, logic [11:0] idx);
      req_type r;
      r.op            = op;
      r.reg_x         = x;
      r.reg_y         = y;
      r.use_flag      = flag;
      r.swap          = swp;
      r.invert        = inv;
      r.value_a       = va;
      r.value_b       = vb;
      r.index_address = idx;
      return r;
   endfunction

   // mix weighted toward register traffic; memory ops cluster on a few bases so
   // loads read back what saves and digit splits wrote, including across the top
   function automatic req_type random_req();
      logic [11:0] hot_base [4] = '{12'd0, 12'd64, 12'd2040, 12'd4088};
      int unsigned pick;
      logic [2:0]  op;
      logic [11:0] idx;
      logic [7:0]  va;
      logic [7:0]  vb;
      pick = $urandom_range(0, 99);
      if (pick < 22)      op = OP_ADD;
      else if (pick < 44) op = OP_SUB;
      else if (pick < 58) op = OP_SKIP;
      else if (pick < 68) op = OP_BCD;
      else if (pick < 80) op = OP_SAVE;
      else if (pick < 94) op = OP_LOAD;
      else if (pick < 97) op = OP_SPARE_LO;
      else                op = OP_SPARE_HI;
      if ($urandom_range(0, 99) < 60)
         idx = hot_base[2'($urandom_range(0, 3))] + 12'($urandom_range(0, 7));
      else
         idx = 12'($urandom_range(0, 4095));
      va = 8'($urandom_range(0, 255));
      // equal compare values half the time so both skip outcomes show up
      vb = $urandom_range(0, 1) ? va : 8'($urandom_range(0, 255));
      return make_req(op, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), va, vb, idx);
   endfunction

   // present one request and hold it until the block takes it
   task automatic send(req_type r);
      // sender idle cycles, drawn per cycle at the current idle rate
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic send_directed(logic [2:0] op, logic [3:0] x, logic [3:0] y, logic flag,
                                logic swp, logic inv, logic [7:0] va, logic [7:0] vb,
                                logic [11:0] idx);
      send(make_req(op, x, y, flag, swp, inv, va, vb, idx));
      directed_sent++;
   endtask

   initial begin
      int unsigned phase_pct [4] = '{0, 70, 0, 36};
      logic [7:0]  va;
      logic        inv;

      idle_pct = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: registers start at zero, so values are built up from the flag
      send_directed(OP_SUB, 4'd0, 4'd0, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 12'd0);   // 0 - 0, no borrow
      send_directed(OP_SUB, 4'd1, 4'd15, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 12'd0);  // 0 - 1 wraps to 255
      send_directed(OP_ADD, 4'd2, 4'd15, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 12'd0);  // r2 = 1
      send_directed(OP_ADD, 4'd1, 4'd2, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 12'd0);   // 255 + 1 carries
      send_directed(OP_SUB, 4'd1, 4'd2, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 12'd0);   // back to 255
      send_directed(OP_ADD, 4'd1, 4'd1, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 12'd0);   // 255 + 255
      // flag write against a result in the flag register itself
      send_directed(OP_ADD, 4'd15, 4'd1, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 12'd0);
      send_directed(OP_SUB, 4'd15, 4'd2, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 12'd0);
      send_directed(OP_SUB, 4'd15, 4'd1, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 12'd0);
      // swapped subtract with and without the flag
      send_directed(OP_SUB, 4'd2, 4'd1, 1'b1, 1'b1, 1'b0, 8'd0, 8'd0, 12'd0);
      send_directed(OP_SUB, 4'd2, 4'd1, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 12'd0);
      send_directed(OP_ADD, 4'd15, 4'd15, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 12'd0);
      // all four compare outcomes at the value extremes
      send_directed(OP_SKIP, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0, 8'd255, 8'd255, 12'd0);
      send_directed(OP_SKIP, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd255, 12'd0);
      send_directed(OP_SKIP, 4'd0, 4'd0, 1'b0, 1'b0, 1'b1, 8'd0, 8'd0, 12'd0);
      send_directed(OP_SKIP, 4'd0, 4'd0, 1'b0, 1'b0, 1'b1, 8'd255, 8'd0, 12'd0);
      // decimal digits, one split wrapping past the end of memory
      send_directed(OP_BCD, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0, 8'd255, 8'd0, 12'd4094);
      send_directed(OP_BCD, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 12'd0);
      send_directed(OP_BCD, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0, 8'd109, 8'd0, 12'd100);
      // save and load, full register range across the wrap and a single register
      send_directed(OP_SAVE, 4'd15, 4'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 12'd4090);
      send_directed(OP_SAVE, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 12'd0);
      send_directed(OP_LOAD, 4'd15, 4'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 12'd4094);
      send_directed(OP_LOAD, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 12'd101);
      // unused op codes leave state alone
      send_directed(OP_SPARE_LO, 4'd15, 4'd15, 1'b1, 1'b1, 1'b1, 8'd255, 8'd255, 12'd4095);
      send_directed(OP_SPARE_HI, 4'd15, 4'd15, 1'b1, 1'b1, 1'b1, 8'd255, 8'd255, 12'd4095);

      // back-to-back taken skips push the program counter far up
      repeat (SWEEP_ITEMS) begin
         va  = 8'($urandom_range(0, 255));
         inv = 1'($urandom_range(0, 1));
         send(make_req(OP_SKIP, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), inv, va,
                       inv ? 8'(va + $urandom_range(1, 255)) : va,
                       12'($urandom_range(0, 4095))));
         sweep_sent++;
      end

      // random requests in four sender phases; the result side cannot stall, so the
      // receiver phase of the plan runs with no idling at all
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = phase_pct[phase];
         repeat (RANDOM_ITEMS / 4) begin
            send(random_req());
            random_sent++;
         end
      end

      // drop start, let the scoreboard see the last request, then drain
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (24) @(posedge clock);

      $display("covered %0d requests: %0d directed, %0d taken skips in a row,",
               directed_sent + sweep_sent + random_sent, directed_sent, sweep_sent);
      $display("  %0d random across idle rates 0/70/0/36 percent; %0d results checked",
               random_sent, checked_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d field mismatches, %0d results missing", mismatch_count, pending_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+sv
sv/vmru_pkg.sv
sv/vmru_alu.sv
sv/vmru_regfile.sv
sv/vmru_mem.sv
sv/vm_register_alu_memory_unit.sv
tb/vm_register_alu_memory_unit_checker.sv
tb/vm_register_alu_memory_unit_tb.sv
